// ===== hdl/rtcp_rsp_pkg.sv =====
// Shared types, constants and helper functions for the RTCP report stream parser.
// Depends on nothing; used by rtcp_rsp_decode, rtcp_rsp_queue and the top level.
package rtcp_rsp_pkg;

    // Report blocks decoded per packet at most
    localparam int MAX_BLOCKS = 4;
    localparam int BIDX_W     = $clog2(MAX_BLOCKS + 1);

    // Byte offset counter
    localparam int          OFF_W   = 19;
    localparam logic [18:0] OFF_MAX = 19'h7ffff;

    // Packet geometry, in bytes
    localparam logic [18:0] HDR_BYTES   = 19'd4;
    localparam logic [18:0] MIN_BYTES   = 19'd8;
    localparam logic [18:0] SR_BASE     = 19'd28;
    localparam logic [18:0] RR_BASE     = 19'd8;
    localparam logic [18:0] BLOCK_BYTES = 19'd24;
    localparam logic [4:0]  BLOCK_LAST  = 5'd23;

    // Last byte offsets of the fixed report fields
    localparam logic [18:0] OFF_SSRC    = 19'd7;
    localparam logic [18:0] OFF_NTP     = 19'd15;
    localparam logic [18:0] OFF_RTP_TS  = 19'd19;
    localparam logic [18:0] OFF_PACKETS = 19'd23;
    localparam logic [18:0] OFF_OCTETS  = 19'd27;

    // Header offsets
    localparam logic [18:0] OFF_COUNT = 19'd0;
    localparam logic [18:0] OFF_TYPE  = 19'd1;
    localparam logic [18:0] OFF_LEN_H = 19'd2;
    localparam logic [18:0] OFF_LEN_L = 19'd3;

    // Payload types
    localparam logic [7:0] PT_SR = 8'd200;
    localparam logic [7:0] PT_RR = 8'd201;

    localparam logic [2:0] BLOCKS_SAT = 3'd7;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        KIND_SSRC,
        KIND_NTP,
        KIND_RTP_TS,
        KIND_PACKETS,
        KIND_OCTETS,
        KIND_BLK_SSRC,
        KIND_FRAC_LOST,
        KIND_CUM_LOST,
        KIND_HIGH_SEQ,
        KIND_JITTER,
        KIND_LSR,
        KIND_DLSR,
        KIND_SUMMARY
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT,
        ST_OVERRUN
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  block_index;
        logic [63:0] value;
        status_t     status;
        logic [4:0]  rcount;
        logic [7:0]  ptype;
        logic [2:0]  blocks;
        logic [18:0] pbytes;
        logic        fin;
    } result_t;

    // Up to two results written into the queue in the same cycle
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } blk_hit_t;

    // Field that ends at a given byte position inside a report block
    function automatic blk_hit_t block_field(input logic [4:0] pos);
        blk_hit_t r;
        r.hit  = 1'b1;
        r.kind = KIND_BLK_SSRC;
        case (pos)
            5'd3:    r.kind = KIND_BLK_SSRC;
            5'd4:    r.kind = KIND_FRAC_LOST;
            5'd7:    r.kind = KIND_CUM_LOST;
            5'd11:   r.kind = KIND_HIGH_SEQ;
            5'd15:   r.kind = KIND_JITTER;
            5'd19:   r.kind = KIND_LSR;
            5'd23:   r.kind = KIND_DLSR;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Value width of each field kind
    function automatic logic [63:0] kind_mask(input kind_t k);
        logic [63:0] m;
        case (k)
            KIND_NTP:       m = 64'hffff_ffff_ffff_ffff;
            KIND_FRAC_LOST: m = 64'h0000_0000_0000_00ff;
            KIND_CUM_LOST:  m = 64'h0000_0000_00ff_ffff;
            default:        m = 64'h0000_0000_ffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/rtcp_rsp_decode.sv =====
// Per-byte RTCP header and report field decoder with its packet state registers.
// Depends on rtcp_rsp_pkg; produces up to two results per accepted word.
module rtcp_rsp_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           data_byte,
    input  logic                 final_byte,
    output rtcp_rsp_pkg::push_t  push
);

    logic [18:0] off_reg,    off_next;
    logic [63:0] shift_reg,  shift_next;
    logic [4:0]  rcount_reg, rcount_next;
    logic [7:0]  ptype_reg,  ptype_next;
    logic [15:0] words_reg,  words_next;
    logic [2:0]  blocks_reg, blocks_next;
    logic [4:0]  bpos_reg,   bpos_next;
    logic [rtcp_rsp_pkg::BIDX_W-1:0] bidx_reg, bidx_next;

    logic [18:0] plen_cur;
    logic [18:0] plen_nx;
    logic [18:0] base;
    logic [18:0] blk_end;
    logic        sr_ok;
    logic        rr;
    logic        in_body;
    logic        in_blocks;
    logic        blk_ok;
    logic        fld_hit;
    rtcp_rsp_pkg::kind_t    fld_kind;
    rtcp_rsp_pkg::blk_hit_t blk_hit;
    rtcp_rsp_pkg::result_t  fld_res;
    rtcp_rsp_pkg::result_t  sum_res;
    rtcp_rsp_pkg::status_t  sum_status;
    logic [18:0] sum_pbytes;

    // Packet geometry from the header already seen
    always_comb
    begin
        plen_cur  = {1'b0, words_reg, 2'b00} + rtcp_rsp_pkg::HDR_BYTES;
        sr_ok     = (ptype_reg == rtcp_rsp_pkg::PT_SR) && (plen_cur >= rtcp_rsp_pkg::SR_BASE);
        rr        = (ptype_reg == rtcp_rsp_pkg::PT_RR);
        base      = sr_ok ? rtcp_rsp_pkg::SR_BASE : (rr ? rtcp_rsp_pkg::RR_BASE : '0);
        in_body   = (off_reg >= rtcp_rsp_pkg::HDR_BYTES) && (off_reg < plen_cur);
        in_blocks = (base != '0) && (off_reg >= base);
        blk_end   = base + rtcp_rsp_pkg::BLOCK_BYTES * (19'(bidx_reg) + 19'd1);
        blk_ok    = in_blocks && (5'(bidx_reg) < rcount_reg)
                    && (int'(bidx_reg) < rtcp_rsp_pkg::MAX_BLOCKS)
                    && (blk_end <= plen_cur);
        blk_hit   = rtcp_rsp_pkg::block_field(bpos_reg);
    end

    // Pick the field that this byte completes, if any
    always_comb
    begin
        fld_hit  = 1'b0;
        fld_kind = rtcp_rsp_pkg::KIND_SSRC;
        if (in_body)
        begin
            if (sr_ok)
            begin
                fld_hit = 1'b1;
                case (off_reg)
                    rtcp_rsp_pkg::OFF_SSRC:    fld_kind = rtcp_rsp_pkg::KIND_SSRC;
                    rtcp_rsp_pkg::OFF_NTP:     fld_kind = rtcp_rsp_pkg::KIND_NTP;
                    rtcp_rsp_pkg::OFF_RTP_TS:  fld_kind = rtcp_rsp_pkg::KIND_RTP_TS;
                    rtcp_rsp_pkg::OFF_PACKETS: fld_kind = rtcp_rsp_pkg::KIND_PACKETS;
                    rtcp_rsp_pkg::OFF_OCTETS:  fld_kind = rtcp_rsp_pkg::KIND_OCTETS;
                    default:                   fld_hit  = 1'b0;
                endcase
            end
            else if (rr && (off_reg == rtcp_rsp_pkg::OFF_SSRC))
            begin
                fld_hit = 1'b1;
            end
            // Report blocks take over once past the fixed part
            if (blk_ok)
            begin
                fld_hit  = blk_hit.hit;
                fld_kind = blk_hit.kind;
            end
        end
    end

    // Next state of the packet registers
    always_comb
    begin
        off_next    = (off_reg != rtcp_rsp_pkg::OFF_MAX) ? off_reg + 19'd1 : off_reg;
        shift_next  = {shift_reg[55:0], data_byte};
        rcount_next = (off_reg == rtcp_rsp_pkg::OFF_COUNT) ? data_byte[4:0] : rcount_reg;
        ptype_next  = (off_reg == rtcp_rsp_pkg::OFF_TYPE) ? data_byte : ptype_reg;
        words_next  = ((off_reg == rtcp_rsp_pkg::OFF_LEN_H) || (off_reg == rtcp_rsp_pkg::OFF_LEN_L))
                      ? {words_reg[7:0], data_byte} : words_reg;
        blocks_next = blocks_reg;
        if (fld_hit && (fld_kind == rtcp_rsp_pkg::KIND_DLSR)
            && (blocks_reg != rtcp_rsp_pkg::BLOCKS_SAT))
        begin
            blocks_next = blocks_reg + 3'd1;
        end
        // Block position tracks the offset past the fixed part
        bpos_next = bpos_reg;
        bidx_next = bidx_reg;
        if ((base != '0) && (off_reg == base - 19'd1))
        begin
            bpos_next = '0;
            bidx_next = '0;
        end
        else if (in_blocks)
        begin
            if (bpos_reg == rtcp_rsp_pkg::BLOCK_LAST)
            begin
                bpos_next = '0;
                if (int'(bidx_reg) < rtcp_rsp_pkg::MAX_BLOCKS)
                begin
                    bidx_next = bidx_reg + rtcp_rsp_pkg::BIDX_W'(1);
                end
            end
            else
            begin
                bpos_next = bpos_reg + 5'd1;
            end
        end
    end

    // Build the field and summary results
    always_comb
    begin
        plen_nx    = {1'b0, words_next, 2'b00} + rtcp_rsp_pkg::HDR_BYTES;
        sum_pbytes = (off_next >= rtcp_rsp_pkg::HDR_BYTES) ? plen_nx : '0;
        if (off_next < rtcp_rsp_pkg::MIN_BYTES)
        begin
            sum_status = rtcp_rsp_pkg::ST_SHORT;
        end
        else if (sum_pbytes > off_next)
        begin
            sum_status = rtcp_rsp_pkg::ST_OVERRUN;
        end
        else
        begin
            sum_status = rtcp_rsp_pkg::ST_OK;
        end

        fld_res.kind        = fld_kind;
        fld_res.block_index = (fld_kind >= rtcp_rsp_pkg::KIND_BLK_SSRC) ? 2'(bidx_reg) : 2'd0;
        fld_res.value       = shift_next & rtcp_rsp_pkg::kind_mask(fld_kind);
        fld_res.status      = rtcp_rsp_pkg::ST_OK;
        fld_res.rcount      = rcount_next;
        fld_res.ptype       = ptype_next;
        fld_res.blocks      = blocks_next;
        fld_res.pbytes      = plen_cur;
        fld_res.fin         = 1'b0;

        sum_res.kind        = rtcp_rsp_pkg::KIND_SUMMARY;
        sum_res.block_index = 2'd0;
        sum_res.value       = '0;
        sum_res.status      = sum_status;
        sum_res.rcount      = rcount_next;
        sum_res.ptype       = ptype_next;
        sum_res.blocks      = blocks_next;
        sum_res.pbytes      = sum_pbytes;
        sum_res.fin         = 1'b1;

        push.first  = fld_hit ? fld_res : sum_res;
        push.second = sum_res;
        push.n      = take ? ({1'b0, fld_hit} + {1'b0, final_byte}) : 2'd0;
    end

    // Advance on each accepted word; clear after the final word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= '0;
            shift_reg  <= '0;
            rcount_reg <= '0;
            ptype_reg  <= '0;
            words_reg  <= '0;
            blocks_reg <= '0;
            bpos_reg   <= '0;
            bidx_reg   <= '0;
        end
        else if (take)
        begin
            if (final_byte)
            begin
                off_reg    <= '0;
                shift_reg  <= '0;
                rcount_reg <= '0;
                ptype_reg  <= '0;
                words_reg  <= '0;
                blocks_reg <= '0;
                bpos_reg   <= '0;
                bidx_reg   <= '0;
            end
            else
            begin
                off_reg    <= off_next;
                shift_reg  <= shift_next;
                rcount_reg <= rcount_next;
                ptype_reg  <= ptype_next;
                words_reg  <= words_next;
                blocks_reg <= blocks_next;
                bpos_reg   <= bpos_next;
                bidx_reg   <= bidx_next;
            end
        end
    end

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && final_byte |=> (off_reg == '0) && (blocks_reg == '0))
        else $error("packet state not cleared after final word");

    a_pair_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> final_byte && push.second.fin)
        else $error("two results without a final word");

    a_offset_advances: assert property (@(posedge clk) disable iff (!rst_n)
        take && !final_byte |=> off_reg != '0)
        else $error("byte offset wrapped");

endmodule

// ===== hdl/rtcp_rsp_queue.sv =====
// Small result queue that takes up to two results a cycle and hands out one.
// Depends on rtcp_rsp_pkg for the result and push types.
module rtcp_rsp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtcp_rsp_pkg::push_t    push,
    input  logic                   pop,
    output logic                   room,
    output logic                   avail,
    output rtcp_rsp_pkg::result_t  head
);

    rtcp_rsp_pkg::result_t entries_reg [rtcp_rsp_pkg::QDEPTH];
    logic [rtcp_rsp_pkg::QAW-1:0] wr_reg,    wr_next;
    logic [rtcp_rsp_pkg::QAW-1:0] rd_reg,    rd_next;
    logic [rtcp_rsp_pkg::QCW-1:0] count_reg, count_next;
    logic [rtcp_rsp_pkg::QAW-1:0] wr_plus1;
    logic                          do_pop;

    // Room for a full pair whatever the reader does
    assign room   = count_reg <= rtcp_rsp_pkg::QCW'(rtcp_rsp_pkg::QDEPTH - 2);
    assign avail  = count_reg != '0;
    assign head   = entries_reg[rd_reg];
    assign do_pop = pop && avail;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_plus1   = wr_reg + rtcp_rsp_pkg::QAW'(1);
        wr_next    = wr_reg + rtcp_rsp_pkg::QAW'(push.n);
        rd_next    = do_pop ? rd_reg + rtcp_rsp_pkg::QAW'(1) : rd_reg;
        count_next = count_reg + rtcp_rsp_pkg::QCW'(push.n)
                     - rtcp_rsp_pkg::QCW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Write the entries; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entries_reg[wr_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            entries_reg[wr_plus1] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rtcp_rsp_pkg::QCW'(rtcp_rsp_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("push into a full result queue");

    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        avail && !pop |=> avail && $stable(head))
        else $error("waiting result word changed");

endmodule

// ===== hdl/rtcp_report_stream_parser.sv =====
// Top level of the RTCP sender/receiver report stream parser.
// Depends on rtcp_rsp_pkg, rtcp_rsp_decode and rtcp_rsp_queue.
//
//  port group   handshake                   contents
//  ----------   -------------------------   ---------------------------------------
//  input word   data_valid / data_ready     data_byte, final_byte
//  result word  result_valid / result_ready field_kind, block_index, field_value,
//                                           parse_status, report_count, payload_type,
//                                           blocks_parsed, packet_bytes, is_final
//
// One input word per cycle while data_ready is high; results are registered in the queue.
// A final word that also completes a field yields two results: the field, then the summary.
// Results wait in a four-entry queue; data_ready drops while fewer than two entries are free.
// Reset clears the offset, header and block state; a final word does the same.
module rtcp_report_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  field_kind,
    output logic [1:0]  block_index,
    output logic [63:0] field_value,
    output logic [1:0]  parse_status,
    output logic [4:0]  report_count,
    output logic [7:0]  payload_type,
    output logic [2:0]  blocks_parsed,
    output logic [18:0] packet_bytes,
    output logic        is_final
);

    logic                  accept;
    rtcp_rsp_pkg::push_t   push;
    rtcp_rsp_pkg::result_t head;

    assign accept = data_valid && data_ready;

    // Decode the word and update the packet state
    rtcp_rsp_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push)
    );

    // Hold results until the consumer takes them
    rtcp_rsp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (result_ready),
        .room  (data_ready),
        .avail (result_valid),
        .head  (head)
    );

    // Drive the result word from the queue head
    assign field_kind    = head.kind;
    assign block_index   = head.block_index;
    assign field_value   = head.value;
    assign parse_status  = head.status;
    assign report_count  = head.rcount;
    assign payload_type  = head.ptype;
    assign blocks_parsed = head.blocks;
    assign packet_bytes  = head.pbytes;
    assign is_final      = head.fin;

endmodule
